// ===== design/stroke_splat_spacing_macros.svh =====
// assertion macros for the stroke splat spacing block
`ifndef STROKE_SPLAT_SPACING_MACROS_SVH
`define STROKE_SPLAT_SPACING_MACROS_SVH

// property checked while out of reset
`define SSS_ASSERT(lbl, clk_i, rstn_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) else $error(msg);

// property checked during reset as well
`define SSS_ASSERT_ALWAYS(lbl, clk_i, prop, msg) \
    lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== design/sss_pkg.sv =====
// shared types and constants of the stroke splat spacing block
package sss_pkg;

    localparam int POS_BITS        = 20;
    localparam int RAD_BITS        = 20;
    localparam int FLOW_BITS       = 8;
    localparam int RATE_BITS       = 12;
    localparam int TRAV_BITS       = 24;
    localparam int FRAC_BITS       = 24;
    localparam int DEF_MAX_SPLATS  = 64;
    localparam int HALF_PIXEL      = 128;
    localparam int RATE_RESET      = 80;
    localparam int DIV_NW          = 48;
    localparam int DIV_DW          = 26;
    localparam int D_BITS          = 21;
    localparam int ADDR_BITS       = 3;
    localparam int DATA_BITS       = 72;

    // register index taken from paddr above the byte offset
    localparam logic REG_SPACING_RATE = 1'b0;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_NEXT  = 2'd1,
        FUNC_END   = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_NEXT,
        CMD_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t              kind;
        logic [POS_BITS-1:0]    x;
        logic [POS_BITS-1:0]    y;
        logic [RAD_BITS-1:0]    r;
        logic [FLOW_BITS-1:0]   f;
        logic [RATE_BITS-1:0]   rate;
    } cmd_t;

    typedef struct packed {
        logic [POS_BITS-1:0]    x;
        logic [POS_BITS-1:0]    y;
        logic [RAD_BITS-1:0]    r;
        logic [FLOW_BITS-1:0]   f;
    } splat_t;

    typedef struct packed {
        splat_t pt;
        logic   last;
        logic   trunc;
    } result_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_START,
        ST_END,
        ST_TA,
        ST_TB,
        ST_SQX,
        ST_SQY,
        ST_SQRT,
        ST_TH_MUL,
        ST_SLACK,
        ST_DECIDE,
        ST_STEP_MUL,
        ST_STEP_DIV,
        ST_T_DIV,
        ST_HIT,
        ST_IMUL,
        ST_IADD,
        ST_MISS,
        ST_FLUSH,
        ST_FINISH
    } back_state_t;

endpackage

// ===== design/sss_div.sv =====
// iterative restoring divider, one quotient bit per cycle
module sss_div
    import sss_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW:0]   rem_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] dvs_reg;
    logic [DW:0]   rem_sh;
    logic          fits;

    assign rem_sh = {rem_reg[DW-1:0], quo_reg[NW-1]};
    assign fits   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? rem_sh - {1'b0, dvs_reg} : rem_sh;
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/sss_fifo.sv =====
// two entry command queue between front and back
module sss_fifo
    import sss_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output cmd_t pop_cmd
);

    cmd_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push;
    logic       do_pop;

    assign full      = cnt_reg == 2'd2;
    assign pop_valid = cnt_reg != 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_cmd   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/sss_front.sv =====
// input acceptance, classification and configuration register
module sss_front
    import sss_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,
    input  logic [1:0]           s_tuser,
    output logic                 push,
    output cmd_t                 push_cmd,
    input  logic                 full
);

    logic [RATE_BITS-1:0] rate_reg;
    logic                 active_reg;
    logic                 accept;
    logic                 keep;

    assign pready   = 1'b1;
    assign prdata   = {{(32 - RATE_BITS){1'b0}}, rate_reg};
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        keep          = 1'b0;
        push_cmd.kind = CMD_NEXT;
        case (s_tuser)
            FUNC_START:
            begin
                keep          = 1'b1;
                push_cmd.kind = CMD_START;
            end
            FUNC_NEXT:
            begin
                keep          = active_reg;
                push_cmd.kind = CMD_NEXT;
            end
            FUNC_END:
            begin
                keep          = active_reg;
                push_cmd.kind = CMD_END;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
        push_cmd.x    = s_tdata[POS_BITS-1:0];
        push_cmd.y    = s_tdata[2*POS_BITS-1:POS_BITS];
        push_cmd.r    = s_tdata[2*POS_BITS+RAD_BITS-1:2*POS_BITS];
        push_cmd.f    = s_tdata[2*POS_BITS+RAD_BITS+FLOW_BITS-1:2*POS_BITS+RAD_BITS];
        // a zero divisor acts as one
        push_cmd.rate = (rate_reg == '0) ? RATE_BITS'(1) : rate_reg;
    end

    assign push = accept && keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg   <= RATE_BITS'(RATE_RESET);
            active_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[ADDR_BITS-1:2] == REG_SPACING_RATE)
            begin
                rate_reg <= pwdata[RATE_BITS-1:0];
            end
            if (accept)
            begin
                case (s_tuser)
                    FUNC_START: active_reg <= 1'b1;
                    FUNC_END:   active_reg <= 1'b0;
                    default:    active_reg <= active_reg;
                endcase
            end
        end
    end

endmodule

// ===== design/sss_back.sv =====
// segment walk sequencer: thresholds, length, splat placement and output stage
module sss_back
    import sss_pkg::*;
#(
    parameter int MAX_SPLATS = DEF_MAX_SPLATS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  cmd_t                 cmd,
    output logic                 cmd_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,
    output logic                 m_tlast,
    output logic [0:0]           m_tuser
);

    localparam int NW = $clog2(MAX_SPLATS + 1);
    localparam logic [NW-1:0] N_MAX = NW'(MAX_SPLATS);

    function automatic logic signed [27:0] trunc_frac(input logic signed [52:0] p);
        logic signed [52:0] adj;
        adj = p[52] ? p + 53'sd16777215 : p;
        return adj[FRAC_BITS+27:FRAC_BITS];
    endfunction

    back_state_t state_reg, state_next;

    cmd_t                     cur_reg;
    splat_t                   held_reg;
    logic [TRAV_BITS-1:0]     trav_reg;
    logic [24:0]              ta_reg, tb_reg;
    logic [D_BITS-1:0]        d_reg, s_reg;
    logic [24:0]              a_reg;
    logic [FRAC_BITS-1:0]     t_reg;
    logic signed [27:0]       slack_reg;
    logic signed [52:0]       mul_reg;
    logic [41:0]              sq_val_reg;
    logic [23:0]              sq_rem_reg;
    logic [D_BITS-1:0]        sq_root_reg;
    logic [4:0]               sq_cnt_reg;
    logic [NW-1:0]            n_reg;
    splat_t                   pend_reg;
    logic                     pend_valid_reg;
    logic                     trunc_reg;
    logic [1:0]               fld_reg;
    logic                     div_run_reg;
    logic                     out_valid_reg;
    result_t                  out_reg;

    logic                     out_free;
    logic                     push_en;
    result_t                  push_res;
    logic                     div_start;
    logic [DIV_NW-1:0]        div_n;
    logic [DIV_DW-1:0]        div_d;
    logic                     div_done;
    logic [DIV_NW-1:0]        div_q;
    logic signed [27:0]       mul_a;
    logic signed [24:0]       mul_b;
    logic signed [52:0]       mul_p;
    logic [POS_BITS-1:0]      dx, dy;
    logic signed [27:0]       dd, d_s, den, base, targ, ith;
    logic [24:0]              thr;
    logic [23:0]              rem_sh, trial;
    logic                     sq_fit;
    logic [D_BITS-1:0]        root_next;
    logic [DIV_NW:0]          s_step;
    logic                     step_ok;

    assign out_free = !out_valid_reg || m_tready;

    assign dx   = (cur_reg.x > held_reg.x) ? cur_reg.x - held_reg.x : held_reg.x - cur_reg.x;
    assign dy   = (cur_reg.y > held_reg.y) ? cur_reg.y - held_reg.y : held_reg.y - cur_reg.y;
    assign dd   = $signed({3'b0, tb_reg}) - $signed({3'b0, ta_reg});
    assign d_s  = $signed({7'b0, d_reg});
    assign den  = d_s - dd;
    assign ith  = $signed({3'b0, ta_reg}) + trunc_frac(mul_reg);
    assign thr  = (div_q < DIV_NW'(HALF_PIXEL)) ? 25'(HALF_PIXEL) : div_q[24:0];

    assign rem_sh    = {sq_rem_reg[21:0], sq_val_reg[41:40]};
    assign trial     = {1'b0, sq_root_reg, 2'b01};
    assign sq_fit    = rem_sh >= trial;
    assign root_next = {sq_root_reg[D_BITS-2:0], sq_fit};

    assign s_step  = {1'b0, div_q} + {{(DIV_NW + 1 - D_BITS){1'b0}}, s_reg};
    assign step_ok = s_step < {{(DIV_NW + 1 - D_BITS){1'b0}}, d_reg};

    // interpolation end points of the field being built
    always_comb
    begin
        case (fld_reg)
            2'd0:
            begin
                base = $signed({8'b0, held_reg.x});
                targ = $signed({8'b0, cur_reg.x});
            end
            2'd1:
            begin
                base = $signed({8'b0, held_reg.y});
                targ = $signed({8'b0, cur_reg.y});
            end
            2'd2:
            begin
                base = $signed({8'b0, held_reg.r});
                targ = $signed({8'b0, cur_reg.r});
            end
            default:
            begin
                base = $signed({20'b0, held_reg.f});
                targ = $signed({20'b0, cur_reg.f});
            end
        endcase
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_SQX:
            begin
                mul_a = $signed({8'b0, dx});
                mul_b = $signed({5'b0, dx});
            end
            ST_SQY:
            begin
                mul_a = $signed({8'b0, dy});
                mul_b = $signed({5'b0, dy});
            end
            ST_TH_MUL:
            begin
                mul_a = dd;
                mul_b = $signed({1'b0, t_reg});
            end
            ST_STEP_MUL:
            begin
                mul_a = slack_reg;
                mul_b = $signed({4'b0, d_reg});
            end
            default:
            begin
                mul_a = targ - base;
                mul_b = $signed({1'b0, t_reg});
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // shared divider operands
    always_comb
    begin
        case (state_reg)
            ST_TA:
            begin
                div_n = {24'b0, held_reg.r, 4'b0};
                div_d = {14'b0, cur_reg.rate};
            end
            ST_TB:
            begin
                div_n = {24'b0, cur_reg.r, 4'b0};
                div_d = {14'b0, cur_reg.rate};
            end
            ST_STEP_DIV:
            begin
                div_n = mul_reg[DIV_NW-1:0] + {22'b0, den[DIV_DW-1:0]} - DIV_NW'(1);
                div_d = den[DIV_DW-1:0];
            end
            default:
            begin
                div_n = {3'b0, s_reg, 24'b0};
                div_d = {5'b0, d_reg};
            end
        endcase
    end

    sss_div #(
        .NW (DIV_NW),
        .DW (DIV_DW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_n),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_q)
    );

    // next state and control
    always_comb
    begin
        state_next = state_reg;
        cmd_pop    = 1'b0;
        push_en    = 1'b0;
        div_start  = 1'b0;
        push_res   = '{pt: pend_reg, last: 1'b0, trunc: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    case (cmd.kind)
                        CMD_START: state_next = ST_START;
                        CMD_NEXT:  state_next = ST_TA;
                        CMD_END:   state_next = ST_END;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_START:
            begin
                push_res = '{pt: '{x: cur_reg.x, y: cur_reg.y, r: cur_reg.r, f: cur_reg.f},
                             last: 1'b1, trunc: 1'b0};
                if (out_free)
                begin
                    push_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_END:
            begin
                push_res = '{pt: held_reg, last: 1'b1, trunc: 1'b0};
                if (out_free)
                begin
                    push_en    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_TA, ST_TB, ST_STEP_DIV, ST_T_DIV:
            begin
                div_start = !div_run_reg;
                if (div_done)
                begin
                    case (state_reg)
                        ST_TA:       state_next = ST_TB;
                        ST_TB:       state_next = ST_SQX;
                        ST_STEP_DIV: state_next = step_ok ? ST_T_DIV : ST_MISS;
                        default:     state_next = ST_HIT;
                    endcase
                end
            end
            ST_SQX:    state_next = ST_SQY;
            ST_SQY:    state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sq_cnt_reg == 5'(D_BITS - 1))
                begin
                    state_next = ST_TH_MUL;
                end
            end
            ST_TH_MUL: state_next = ST_SLACK;
            ST_SLACK:  state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                if (slack_reg < 0)
                begin
                    state_next = ST_HIT;
                end
                else if (dd < d_s)
                begin
                    state_next = ST_STEP_MUL;
                end
                else
                begin
                    state_next = ST_MISS;
                end
            end
            ST_STEP_MUL: state_next = ST_STEP_DIV;
            ST_HIT:
            begin
                if (n_reg >= N_MAX)
                begin
                    state_next = ST_FLUSH;
                end
                else if (pend_valid_reg)
                begin
                    push_en = out_free;
                end
                else
                begin
                    state_next = ST_IMUL;
                end
            end
            ST_IMUL: state_next = ST_IADD;
            ST_IADD: state_next = (fld_reg == 2'd3) ? ST_TH_MUL : ST_IMUL;
            ST_MISS: state_next = ST_FLUSH;
            ST_FLUSH:
            begin
                push_res = '{pt: pend_reg, last: 1'b1, trunc: trunc_reg};
                if (!pend_valid_reg)
                begin
                    state_next = ST_FINISH;
                end
                else if (out_free)
                begin
                    push_en    = 1'b1;
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            trav_reg       <= '0;
            pend_valid_reg <= 1'b0;
            div_run_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_start)
            begin
                div_run_reg <= 1'b1;
            end
            else if (div_done)
            begin
                div_run_reg <= 1'b0;
            end
            if (push_en)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    pend_valid_reg <= 1'b0;
                end
                ST_START:
                begin
                    if (out_free)
                    begin
                        held_reg <= '{x: cur_reg.x, y: cur_reg.y, r: cur_reg.r, f: cur_reg.f};
                        trav_reg <= '0;
                    end
                end
                ST_END:
                begin
                    if (out_free)
                    begin
                        trav_reg <= '0;
                    end
                end
                ST_HIT:
                begin
                    if (n_reg < N_MAX && pend_valid_reg && out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                ST_IADD:
                begin
                    if (fld_reg == 2'd3)
                    begin
                        pend_valid_reg <= 1'b1;
                    end
                end
                ST_FLUSH:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                    end
                end
                ST_FINISH:
                begin
                    trav_reg <= a_reg[24] ? {TRAV_BITS{1'b1}} : a_reg[TRAV_BITS-1:0];
                    held_reg <= '{x: cur_reg.x, y: cur_reg.y, r: cur_reg.r, f: cur_reg.f};
                end
                default:
                begin
                    pend_valid_reg <= pend_valid_reg;
                end
            endcase
        end
    end

    // walk datapath
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            out_reg <= push_res;
        end
        case (state_reg)
            ST_IDLE:
            begin
                cur_reg   <= cmd;
                n_reg     <= '0;
                trunc_reg <= 1'b0;
                s_reg     <= '0;
                t_reg     <= '0;
                a_reg     <= {1'b0, trav_reg};
            end
            ST_TA:
            begin
                if (div_done)
                begin
                    ta_reg <= thr;
                end
            end
            ST_TB:
            begin
                if (div_done)
                begin
                    tb_reg <= thr;
                end
            end
            ST_SQX:
            begin
                mul_reg <= mul_p;
            end
            ST_SQY:
            begin
                sq_val_reg  <= mul_reg[41:0] + mul_p[41:0];
                sq_rem_reg  <= '0;
                sq_root_reg <= '0;
                sq_cnt_reg  <= '0;
            end
            ST_SQRT:
            begin
                sq_val_reg  <= {sq_val_reg[39:0], 2'b00};
                sq_rem_reg  <= sq_fit ? rem_sh - trial : rem_sh;
                sq_root_reg <= root_next;
                sq_cnt_reg  <= sq_cnt_reg + 1'b1;
                d_reg       <= root_next;
            end
            ST_TH_MUL, ST_STEP_MUL, ST_IMUL:
            begin
                mul_reg <= mul_p;
            end
            ST_SLACK:
            begin
                slack_reg <= ith - $signed({3'b0, a_reg});
            end
            ST_STEP_DIV:
            begin
                if (div_done && step_ok)
                begin
                    s_reg <= s_step[D_BITS-1:0];
                end
            end
            ST_T_DIV:
            begin
                if (div_done)
                begin
                    t_reg <= div_q[FRAC_BITS-1:0];
                end
            end
            ST_HIT:
            begin
                fld_reg <= 2'd0;
                if (n_reg >= N_MAX)
                begin
                    trunc_reg <= 1'b1;
                    a_reg     <= '0;
                end
            end
            ST_IADD:
            begin
                case (fld_reg)
                    2'd0:    pend_reg.x <= 20'(base + trunc_frac(mul_reg));
                    2'd1:    pend_reg.y <= 20'(base + trunc_frac(mul_reg));
                    2'd2:    pend_reg.r <= 20'(base + trunc_frac(mul_reg));
                    default: pend_reg.f <= 8'(base + trunc_frac(mul_reg));
                endcase
                fld_reg <= fld_reg + 1'b1;
                if (fld_reg == 2'd3)
                begin
                    n_reg <= n_reg + 1'b1;
                    a_reg <= '0;
                end
            end
            ST_MISS:
            begin
                a_reg <= a_reg + {4'b0, d_reg} - {4'b0, s_reg};
            end
            default:
            begin
                fld_reg <= fld_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_reg.pt.f, out_reg.pt.r, out_reg.pt.y, out_reg.pt.x};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.trunc;

endmodule

// ===== design/stroke_splat_spacing.sv =====
// top level of the brush stroke splat spacing resampler
// start and end: one result each
// next point: two divisions for the thresholds, then length and sqrt, then per splat
//   up to two more divisions on the shared divider
// input queue of two commands and one output register decouple both streams
// reset (rst_n low, asynchronous) clears stroke state, queue and output; spacing_rate returns to 80
module stroke_splat_spacing
    import sss_pkg::*;
#(
    parameter int MAX_SPLATS = DEF_MAX_SPLATS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // stroke points
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [DATA_BITS-1:0] s_tdata,   // pos_x, pos_y, radius, flow, zero pad
    input  logic [1:0]           s_tuser,   // func
    // splats
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [DATA_BITS-1:0] m_tdata,   // splat_x, splat_y, splat_radius, splat_flow, pad
    output logic                 m_tlast,
    output logic [0:0]           m_tuser    // truncated
);

    // commands that survive classification; ignored transactions never reach the queue
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    sss_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full)
    );

    // short queue so the front keeps taking points while a segment is walked
    sss_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (full),
        .pop       (pop),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd)
    );

    // sequencer with shared divider and multiplier; one result held back until
    // the next pass knows whether it is the last
    sss_back #(
        .MAX_SPLATS (MAX_SPLATS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (pop_valid),
        .cmd       (pop_cmd),
        .cmd_pop   (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

// ===== design/sss_checker.sv =====
// port level checks for the stroke splat spacing block and their binding
`include "stroke_splat_spacing_macros.svh"

module sss_checker
    import sss_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 psel,
    input logic                 penable,
    input logic                 pwrite,
    input logic [ADDR_BITS-1:0] paddr,
    input logic [31:0]          pwdata,
    input logic [31:0]          prdata,
    input logic                 pready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic                 m_tlast,
    input logic [0:0]           m_tuser
);

    `SSS_ASSERT(a_out_hold, clk, rst_n, m_tvalid && !m_tready |=> m_tvalid, "splat transaction dropped while stalled")
    `SSS_ASSERT(a_trunc_last, clk, rst_n, m_tvalid && m_tuser[0] |-> m_tlast, "truncated flag without last")
    `SSS_ASSERT(a_cfg_readback, clk, rst_n, psel && penable && pwrite && pready && paddr[ADDR_BITS-1:2] == REG_SPACING_RATE |=> prdata[RATE_BITS-1:0] == $past(pwdata[RATE_BITS-1:0]), "spacing rate not written")
    `SSS_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !m_tvalid && pready, "output active in reset")

endmodule

bind stroke_splat_spacing sss_checker u_sss_checker (.*);
